@@ hw/rtl/voxel_face_visibility_texels_assert.svh @@
// Assertion macros for the voxel face visibility block.
// Included by the top level; the checks drop out when SYNTHESIS is defined.
`ifndef VOXEL_FACE_VISIBILITY_TEXELS_ASSERT_SVH
`define VOXEL_FACE_VISIBILITY_TEXELS_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication, sampled on i_clk, off during reset
`define VFVT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("vfvt assertion failed");
// next-cycle implication, sampled on i_clk, off during reset
`define VFVT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("vfvt assertion failed");
`else
`define VFVT_ASSERT_NOW(label, ante, cons)
`define VFVT_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ hw/rtl/vfvt_pkg.sv @@
// Shared types, codes and the palette for the voxel face visibility block.
// No dependencies; every RTL file of the block imports it.
`default_nettype none

package vfvt_pkg;

    // store geometry
    localparam int MAX_LAYERS  = 64;
    localparam int STORE_DEPTH = MAX_LAYERS * 256;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int HGT_W       = 7;

    // op queue between front and back
    localparam int OPQ_DEPTH = 2;
    localparam int OPQ_AW    = $clog2(OPQ_DEPTH);

    // input commands
    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_PUT   = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;
    localparam logic [1:0] CMD_NONE  = 2'd3;

    // decoded op kinds
    localparam logic [1:0] OP_NULL  = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_PUT   = 2'd2;
    localparam logic [1:0] OP_QUERY = 2'd3;

    // faces
    localparam logic [2:0] FACE_NX = 3'd0;
    localparam logic [2:0] FACE_PX = 3'd1;
    localparam logic [2:0] FACE_NY = 3'd2;
    localparam logic [2:0] FACE_PY = 3'd3;
    localparam logic [2:0] FACE_NZ = 3'd4;
    localparam logic [2:0] FACE_PZ = 3'd5;

    // palette colors, ARGB
    localparam logic [31:0] PAL_WHITE = 32'hFFFFFFFF;
    localparam logic [31:0] PAL_BLUE  = 32'hFF0000FF;
    localparam logic [31:0] PAL_GREEN = 32'hFF00FF00;
    localparam logic [31:0] PAL_RED   = 32'hFFFF0000;
    localparam logic [31:0] PAL_DARK  = 32'hFF222222;
    localparam logic [31:0] PAL_GREY  = 32'hFF777777;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [3:0]  cell_x;
        logic [3:0]  cell_y;
        logic [5:0]  cell_z;
        logic [7:0]  block_value;
        logic [2:0]  face;
        logic [13:0] texel_index;
    } t_in;

    typedef struct packed {
        logic [31:0] texel_color;
        logic        put_accepted;
        logic        index_error;
    } t_out;

    typedef struct packed {
        logic [1:0]        kind;
        logic              err;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        value;
        logic [2:0]        face;
        logic [13:0]       idx;
        logic [HGT_W-1:0]  hgt;
    } t_op;

    function automatic logic [31:0] colour_of(input logic [7:0] code);
        logic [31:0] c;
        case (code)
            8'd1:    c = PAL_WHITE;
            8'd2:    c = PAL_BLUE;
            8'd3:    c = PAL_GREEN;
            8'd4:    c = PAL_RED;
            8'd5:    c = PAL_DARK;
            8'd6:    c = PAL_GREY;
            default: c = 32'd0;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/vfvt_front.sv @@
// Front end: holds the height register, range-checks and decodes each input word.
// Depends on vfvt_pkg; feeds vfvt_opq.
`default_nettype none

module vfvt_front import vfvt_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [HGT_W-1:0] i_cfg_data,
    input  wire logic             i_push,
    input  wire t_in              i_in_word,
    input  wire logic             i_full,
    output logic                  o_op_push,
    output t_op                   o_op_word
);

    logic [HGT_W-1:0] r_height;
    logic [HGT_W-1:0] hgt;
    logic             z_bad;
    logic             idx_bad;

    // hold the height register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_height <= HGT_W'(1);
        end else if (i_cfg_we) begin
            r_height <= i_cfg_data;
        end
    end

    // saturate height, check layer and texel range
    always_comb begin
        hgt     = (int'(r_height) > MAX_LAYERS) ? HGT_W'(MAX_LAYERS) : r_height;
        z_bad   = ({1'b0, i_in_word.cell_z} >= hgt);
        idx_bad = ({1'b0, i_in_word.texel_index} >= {hgt, 8'h00});
    end

    // decode the word into an op
    always_comb begin
        o_op_word.kind  = OP_NULL;
        o_op_word.err   = 1'b0;
        o_op_word.addr  = ADDR_W'({i_in_word.cell_z, i_in_word.cell_y, i_in_word.cell_x});
        o_op_word.value = i_in_word.block_value;
        o_op_word.face  = i_in_word.face;
        o_op_word.idx   = i_in_word.texel_index;
        o_op_word.hgt   = hgt;
        case (i_in_word.cmd)
            CMD_LOAD, CMD_PUT: begin
                if (z_bad) begin
                    o_op_word.err = 1'b1;
                end else begin
                    o_op_word.kind = (i_in_word.cmd == CMD_LOAD) ? OP_LOAD : OP_PUT;
                end
            end
            CMD_QUERY: begin
                if (idx_bad) begin
                    o_op_word.err = 1'b1;
                end else if (i_in_word.face inside {[FACE_NX:FACE_PZ]}) begin
                    o_op_word.kind = OP_QUERY;
                end
            end
            default: begin
                o_op_word.kind = OP_NULL;
            end
        endcase
    end

    // drop the unused command, push everything else
    assign o_op_push = i_push && !i_full && (i_in_word.cmd != CMD_NONE);

endmodule

`default_nettype wire

@@ hw/rtl/vfvt_opq.sv @@
// Short op queue that decouples the front end from the back end.
// Depends on vfvt_pkg for t_op and the queue depth.
`default_nettype none

module vfvt_opq import vfvt_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_op  i_wdata,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_empty,
    output t_op       o_rdata
);

    t_op               r_slot [OPQ_DEPTH];
    logic [OPQ_AW-1:0] r_wptr;
    logic [OPQ_AW-1:0] r_rptr;
    logic [OPQ_AW:0]   r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == (OPQ_AW+1)'(OPQ_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_rdata = r_slot[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (int'(r_wptr) == OPQ_DEPTH - 1) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (int'(r_rptr) == OPQ_DEPTH - 1) ? '0 : r_rptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // store the pushed word
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wptr] <= i_wdata;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/vfvt_back.sv @@
// Back end: voxel store, texel-index divider and the read sequencer per op.
// Depends on vfvt_pkg; takes ops from vfvt_opq and holds the result word.
`default_nettype none

module vfvt_back import vfvt_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_op_empty,
    input  wire t_op  i_op_word,
    output logic      o_op_pop,
    input  wire logic i_pop,
    output logic      o_empty,
    output t_out      o_out_word
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_CEN  = 3'd2;
    localparam logic [2:0] S_NBR  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;
    localparam logic [2:0] S_PUTD = 3'd5;

    logic [7:0]        r_store [STORE_DEPTH];
    logic [7:0]        r_rdata;
    logic [2:0]        r_state;
    logic [2:0]        n_state;
    t_op               r_op;
    logic [1:0]        r_step;
    logic [9:0]        r_rem;
    logic [9:0]        r_dvs;
    logic [3:0]        r_quo;
    logic [3:0]        r_x;
    logic [3:0]        r_y;
    logic [5:0]        r_z;
    logic [7:0]        r_cdata;
    t_out              r_res;
    t_out              n_res;
    logic              r_res_valid;
    logic              n_res_valid;

    logic              start;
    logic              res_load;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [7:0]        mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;
    logic [ADDR_W-1:0] cen_addr;
    logic [ADDR_W-1:0] nbr_addr;
    logic [3:0]        nx;
    logic [3:0]        ny;
    logic [5:0]        nz;
    logic              edge_side;
    logic              ge;
    logic [9:0]        rem_nx;
    logic [3:0]        quo_nx;
    logic              open_side;

    assign o_empty    = !r_res_valid;
    assign o_out_word = r_res;
    assign start      = (r_state == S_IDLE) && !i_op_empty && (!r_res_valid || i_pop);
    assign o_op_pop   = start;

    // one divide step: compare and subtract
    always_comb begin
        ge     = (r_rem >= r_dvs);
        rem_nx = ge ? (r_rem - r_dvs) : r_rem;
        quo_nx = {r_quo[2:0], ge};
    end

    // neighbor cell and chunk edge for the face
    always_comb begin
        nx        = r_x;
        ny        = r_y;
        nz        = r_z;
        edge_side = 1'b0;
        case (r_op.face)
            FACE_NX: begin
                edge_side = (r_x == 4'd0);
                nx        = r_x - 4'd1;
            end
            FACE_PX: begin
                edge_side = (r_x == 4'd15);
                nx        = r_x + 4'd1;
            end
            FACE_NY: begin
                edge_side = (r_y == 4'd0);
                ny        = r_y - 4'd1;
            end
            FACE_PY: begin
                edge_side = (r_y == 4'd15);
                ny        = r_y + 4'd1;
            end
            FACE_NZ: begin
                edge_side = (r_z == 6'd0);
                nz        = r_z - 6'd1;
            end
            FACE_PZ: begin
                edge_side = (({1'b0, r_z} + 7'd1) >= r_op.hgt);
                nz        = r_z + 6'd1;
            end
            default: begin
                edge_side = 1'b1;
            end
        endcase
        cen_addr = ADDR_W'({r_z, r_y, r_x});
        nbr_addr = ADDR_W'({nz, ny, nx});
    end

    // select the store read address by step
    always_comb begin
        case (r_state)
            S_IDLE:  mem_raddr = i_op_word.addr;
            S_NBR:   mem_raddr = nbr_addr;
            default: mem_raddr = cen_addr;
        endcase
    end

    // sequencer, store writes and the result word
    always_comb begin
        n_state     = r_state;
        n_res       = r_res;
        n_res_valid = r_res_valid && !i_pop;
        res_load    = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = r_op.addr;
        mem_wdata   = r_op.value;
        open_side   = edge_side || (r_rdata == 8'd0);
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (i_op_word.kind)
                        OP_NULL: begin
                            res_load = 1'b1;
                            n_res    = '{texel_color: 32'd0, put_accepted: 1'b0,
                                         index_error: i_op_word.err};
                        end
                        OP_LOAD: begin
                            mem_we    = 1'b1;
                            mem_waddr = i_op_word.addr;
                            mem_wdata = i_op_word.value;
                            res_load  = 1'b1;
                            n_res     = '0;
                        end
                        OP_PUT: begin
                            n_state = S_PUTD;
                        end
                        default: begin
                            if (i_op_word.face == FACE_NZ || i_op_word.face == FACE_PZ) begin
                                n_state = S_CEN;
                            end else begin
                                n_state = S_DIV;
                            end
                        end
                    endcase
                end
            end
            S_DIV: begin
                if (r_step == 2'd0) begin
                    n_state = S_CEN;
                end
            end
            S_CEN: begin
                n_state = S_NBR;
            end
            S_NBR: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                res_load = 1'b1;
                n_res    = '{texel_color: open_side ? colour_of(r_cdata) : 32'd0,
                             put_accepted: 1'b0, index_error: 1'b0};
                n_state  = S_IDLE;
            end
            S_PUTD: begin
                res_load = 1'b1;
                n_res    = '0;
                if (r_rdata == 8'd0 || r_op.value == 8'd0) begin
                    mem_we             = 1'b1;
                    n_res.put_accepted = 1'b1;
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (res_load) begin
            n_res_valid = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_res_valid <= n_res_valid;
        end
    end

    // datapath registers: op, divider, coordinates, result
    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    r_op   <= i_op_word;
                    r_rem  <= i_op_word.idx[13:4];
                    r_dvs  <= {i_op_word.hgt, 3'b000};
                    r_quo  <= 4'd0;
                    r_step <= 2'd3;
                    r_x    <= i_op_word.idx[3:0];
                    r_y    <= i_op_word.idx[7:4];
                    r_z    <= i_op_word.idx[13:8];
                end
            end
            S_DIV: begin
                r_rem  <= rem_nx;
                r_quo  <= quo_nx;
                r_dvs  <= {1'b0, r_dvs[9:1]};
                r_step <= r_step - 2'd1;
                if (r_step == 2'd0) begin
                    r_z <= rem_nx[5:0];
                    if (r_op.face == FACE_NX || r_op.face == FACE_PX) begin
                        r_x <= quo_nx;
                        r_y <= r_op.idx[3:0];
                    end else begin
                        r_x <= r_op.idx[3:0];
                        r_y <= quo_nx;
                    end
                end
            end
            S_NBR: begin
                r_cdata <= r_rdata;
            end
            default: begin
                r_cdata <= r_cdata;
            end
        endcase
    end

    // voxel store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_store[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_store[mem_raddr];
    end

endmodule

`default_nettype wire

@@ hw/rtl/voxel_face_visibility_texels.sv @@
// Top level of the voxel face visibility block: front end, op queue, back end.
// Depends on vfvt_pkg, vfvt_front, vfvt_opq, vfvt_back and the assertion header.
`default_nettype none

`include "voxel_face_visibility_texels_assert.svh"

// Keeps a 16x16xH chunk of 8-bit block codes and answers face texel queries.
// Input words enter through a queue-like push/full port and results leave
// through empty/pop, one result word per load, put or query (command three is
// taken and dropped). The front end decodes and range-checks each word in the
// cycle it is taken and parks it in a two-entry op queue, so input keeps
// flowing while the back end works or a result waits. The back end runs one
// op at a time against a store with one write port and one registered read
// port. A range error, face six or seven, or a load finishes in the idle state;
// a put reads, then conditionally writes; a query does the 4-step restoring
// divide of the texel index by the height (x and y faces only), then the two
// store reads for the cell and its neighbor. The user must write the height
// through i_cfg_we/i_cfg_data only while the block is idle; the block does not
// enforce it. With no store reset, an unwritten cell gives an undefined color.
module voxel_face_visibility_texels import vfvt_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [HGT_W-1:0] i_cfg_data,
    input  wire logic             push,
    output logic                  full,
    input  wire t_in              i_in_word,
    output logic                  empty,
    input  wire logic             pop,
    output t_out                  o_out_word
);

    logic w_opq_push;
    t_op  w_opq_wdata;
    logic w_opq_full;
    logic w_opq_pop;
    logic w_opq_empty;
    t_op  w_opq_rdata;

    assign full = w_opq_full;

    // decode and check input words
    vfvt_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_push     (push),
        .i_in_word  (i_in_word),
        .i_full     (w_opq_full),
        .o_op_push  (w_opq_push),
        .o_op_word  (w_opq_wdata)
    );

    // buffer decoded ops
    vfvt_opq u_opq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_opq_push),
        .i_wdata (w_opq_wdata),
        .o_full  (w_opq_full),
        .i_pop   (w_opq_pop),
        .o_empty (w_opq_empty),
        .o_rdata (w_opq_rdata)
    );

    // execute ops against the voxel store
    vfvt_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op_empty (w_opq_empty),
        .i_op_word  (w_opq_rdata),
        .o_op_pop   (w_opq_pop),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_out_word (o_out_word)
    );

    // back end takes an op only when the result slot is free or draining
    `VFVT_ASSERT_NOW(a_take_needs_slot, w_opq_pop, !w_opq_empty && (empty || pop))
    // front end never pushes into a full queue
    `VFVT_ASSERT_NOW(a_no_push_when_full, w_opq_full, !w_opq_push)
    // an op with no store work yields its result in the next cycle
    `VFVT_ASSERT_NEXT(a_null_result_next, w_opq_pop && (w_opq_rdata.kind == OP_NULL), !empty)
    // an error result never carries a color or a put acceptance
    `VFVT_ASSERT_NOW(a_error_result_clean, !empty && o_out_word.index_error,
        (o_out_word.texel_color == 32'd0) && !o_out_word.put_accepted)

endmodule

`default_nettype wire

@@ tb/vfvt_texel_checker.sv @@
`timescale 1ns / 100ps
// Result checker for the voxel face visibility block: mirrors the voxel chunk,
// predicts each result word from the accepted input words and compares it.
// Depends on vfvt_pkg for the word types, commands, faces and palette colors.

module vfvt_texel_checker import vfvt_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [HGT_W-1:0] i_cfg_data,
    input  logic             i_push,
    input  logic             i_full,
    input  t_in              i_in_word,
    input  logic             i_empty,
    input  logic             i_pop,
    input  t_out             i_out_word,
    output int               o_fail_count,
    output int               o_pending
);

    // mirror of the chunk and the height register
    logic [7:0]       chunk_cells [0:STORE_DEPTH-1];
    logic [HGT_W-1:0] layer_reg;
    t_out             awaited_words [$];
    t_out             want;
    logic             bad_word;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        layer_reg    = 7'd1;
    end

    // saturate the programmed height at the store depth
    function automatic int unsigned layers_in_use();
        return (layer_reg > MAX_LAYERS) ? MAX_LAYERS : int'(layer_reg);
    endfunction

    // cells past the top of the store read as empty
    function automatic logic [7:0] code_at(int unsigned x, int unsigned y, int unsigned z);
        int unsigned a;
        a = (x & 15) + ((y & 15) << 4) + (z << 8);
        if (a >= STORE_DEPTH)
            return 8'd0;
        return chunk_cells[a];
    endfunction

    function automatic logic [31:0] argb_of(logic [7:0] code);
        case (code)
            8'd1:    return PAL_WHITE;
            8'd2:    return PAL_BLUE;
            8'd3:    return PAL_GREEN;
            8'd4:    return PAL_RED;
            8'd5:    return PAL_DARK;
            8'd6:    return PAL_GREY;
            default: return 32'd0;
        endcase
    endfunction

    // map the texel to a cell, then show its color only if the side is open
    function automatic logic [31:0] face_color(logic [2:0] face, int unsigned idx,
                                               int unsigned hgt);
        int unsigned span;
        int unsigned x;
        int unsigned y;
        int unsigned z;
        bit          open_side;
        span = 16 * hgt;
        case (face)
            FACE_NX, FACE_PX: begin
                x = idx / span;
                y = idx % 16;
                z = (idx % span) / 16;
            end
            FACE_NY, FACE_PY: begin
                x = idx % 16;
                y = idx / span;
                z = (idx % span) / 16;
            end
            FACE_NZ, FACE_PZ: begin
                x = idx % 16;
                y = (idx / 16) % 16;
                z = idx / 256;
            end
            default: return 32'd0;
        endcase
        case (face)
            FACE_NX: open_side = (x == 0)       || (code_at(x - 1, y, z) == 8'd0);
            FACE_PX: open_side = (x == 15)      || (code_at(x + 1, y, z) == 8'd0);
            FACE_NY: open_side = (y == 0)       || (code_at(x, y - 1, z) == 8'd0);
            FACE_PY: open_side = (y == 15)      || (code_at(x, y + 1, z) == 8'd0);
            FACE_NZ: open_side = (z == 0)       || (code_at(x, y, z - 1) == 8'd0);
            default: open_side = (z + 1 >= hgt) || (code_at(x, y, z + 1) == 8'd0);
        endcase
        return open_side ? argb_of(code_at(x, y, z)) : 32'd0;
    endfunction

    // apply one load, put or query to the mirror and return its result word
    function automatic t_out apply_word(t_in w);
        t_out                r;
        int unsigned         hgt;
        logic [ADDR_W-1:0]   a;
        r   = '0;
        hgt = layers_in_use();
        a   = {w.cell_z, w.cell_y, w.cell_x};
        if (w.cmd == CMD_QUERY) begin
            if (w.texel_index >= 256 * hgt)
                r.index_error = 1'b1;
            else
                r.texel_color = face_color(w.face, 32'(w.texel_index), hgt);
        end else if (w.cell_z >= hgt) begin
            r.index_error = 1'b1;
        end else if (w.cmd == CMD_LOAD) begin
            chunk_cells[a] = w.block_value;
        end else if (chunk_cells[a] == 8'd0 || w.block_value == 8'd0) begin
            chunk_cells[a]  = w.block_value;
            r.put_accepted  = 1'b1;
        end
        return r;
    endfunction

    // track config, check popped words, queue predictions for pushed words
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            awaited_words.delete();
            layer_reg = 7'd1;
        end else begin
            if (i_cfg_we)
                layer_reg = i_cfg_data;
            if (i_pop && !i_empty) begin
                if (awaited_words.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("%0t: result word with none awaited: color %h acc %b err %b",
                                 $realtime, i_out_word.texel_color,
                                 i_out_word.put_accepted, i_out_word.index_error);
                end else begin
                    want     = awaited_words.pop_front();
                    bad_word = (i_out_word.texel_color  !== want.texel_color)  ||
                               (i_out_word.put_accepted !== want.put_accepted) ||
                               (i_out_word.index_error  !== want.index_error);
                    if (bad_word) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("%0t: mismatch: expected color %h acc %b err %b, %s %h %b %b",
                                     $realtime, want.texel_color, want.put_accepted,
                                     want.index_error, "got",
                                     i_out_word.texel_color, i_out_word.put_accepted,
                                     i_out_word.index_error);
                    end
                end
            end
            if (i_push && !i_full && i_in_word.cmd != CMD_NONE)
                awaited_words.push_back(apply_word(i_in_word));
        end
        o_pending = awaited_words.size();
    end

endmodule

@@ tb/voxel_face_visibility_texels_test.sv @@
`timescale 1ns / 100ps
// Top of the voxel face visibility testbench: clock, reset, height settings and
// load/put/query stimulus. Depends on vfvt_pkg, the block and vfvt_texel_checker.

module voxel_face_visibility_texels_test;
    import vfvt_pkg::*;

    // faces past the last real one
    localparam logic [2:0] FACE_ODD_LO = 3'd6;
    localparam logic [2:0] FACE_ODD_HI = 3'd7;
    localparam int         MAX_INDEX   = 16383;
    localparam int         HOLD_CYCLES = 400;

    logic             clk      = 1'b0;
    logic             rst_n    = 1'b0;
    logic             cfg_we   = 1'b0;
    logic [HGT_W-1:0] cfg_data = '0;
    logic             push     = 1'b0;
    logic             full;
    t_in              in_word  = '0;
    logic             empty;
    logic             pop      = 1'b0;
    t_out             out_word;
    int               fail_count;
    int               pending;

    // stimulus state
    bit          filled [0:STORE_DEPTH-1];
    int unsigned hgt_eff    = 1;
    bit          allow_idle = 1'b1;
    bit          tx_quiet   = 1'b0;
    bit          rx_quiet   = 1'b0;
    bit          hold_req   = 1'b0;

    voxel_face_visibility_texels dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .push       (push),
        .full       (full),
        .i_in_word  (in_word),
        .empty      (empty),
        .pop        (pop),
        .o_out_word (out_word)
    );

    vfvt_texel_checker u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (cfg_data),
        .i_push       (push),
        .i_full       (full),
        .i_in_word    (in_word),
        .i_empty      (empty),
        .i_pop        (pop),
        .i_out_word   (out_word),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #6 clk = ~clk;

    // hard stop
    initial begin
        #12_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // result side: pop with random stalls, plus one long hold-off on request
    initial begin
        forever begin
            if (hold_req) begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end else if (allow_idle && !rx_quiet && $urandom_range(0, 5) == 0) begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end else begin
                pop <= 1'b1;
                @(posedge clk);
            end
            if ($urandom_range(0, 59) == 0)
                rx_quiet = ($urandom_range(0, 2) == 0);
        end
    end

    function automatic t_in make_word(logic [1:0] cmd, logic [3:0] x, logic [3:0] y,
                                      logic [5:0] z, logic [7:0] val, logic [2:0] face,
                                      logic [13:0] idx);
        t_in w;
        w.cmd         = cmd;
        w.cell_x      = x;
        w.cell_y      = y;
        w.cell_z      = z;
        w.block_value = val;
        w.face        = face;
        w.texel_index = idx;
        return w;
    endfunction

    function automatic t_in random_word(logic [1:0] cmd);
        return make_word(cmd, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                         6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)),
                         3'($urandom_range(0, 7)), 14'($urandom_range(0, MAX_INDEX)));
    endfunction

    // mostly empty or codes 1 to 7, now and then any code
    function automatic logic [7:0] random_code();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 3)
            return 8'd0;
        if (r < 9)
            return 8'($urandom_range(1, 7));
        return 8'($urandom_range(0, 255));
    endfunction

    // offer one word, wait for room, let the next edge take it, maybe idle
    task automatic send_word(input t_in w);
        in_word <= w;
        push    <= 1'b1;
        @(negedge clk);
        while (full) @(negedge clk);
        @(posedge clk);
        if (allow_idle && !tx_quiet && $urandom_range(0, 4) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
    endtask

    task automatic load_cell(input logic [3:0] x, input logic [3:0] y,
                             input logic [5:0] z, input logic [7:0] val);
        send_word(make_word(CMD_LOAD, x, y, z, val, 3'($urandom_range(0, 7)),
                            14'($urandom_range(0, MAX_INDEX))));
        if (z < hgt_eff)
            filled[{z, y, x}] = 1'b1;
    endtask

    // make sure a cell the block will read holds a known code
    task automatic fill_cell(input int unsigned x, input int unsigned y, input int unsigned z);
        if (!filled[{z[5:0], y[3:0], x[3:0]}])
            load_cell(x[3:0], y[3:0], z[5:0], random_code());
    endtask

    task automatic put_cell(input logic [3:0] x, input logic [3:0] y,
                            input logic [5:0] z, input logic [7:0] val);
        if (z < hgt_eff)
            fill_cell(32'(x), 32'(y), 32'(z));
        send_word(make_word(CMD_PUT, x, y, z, val, 3'($urandom_range(0, 7)),
                            14'($urandom_range(0, MAX_INDEX))));
    endtask

    // fill the texel's cell and its neighbor first, then ask for the texel
    task automatic query_texel(input logic [2:0] face, input int unsigned idx);
        int unsigned span;
        int unsigned x;
        int unsigned y;
        int unsigned z;
        int unsigned nx;
        int unsigned ny;
        int unsigned nz;
        bit          has_nb;
        if (face <= FACE_PZ && idx < 256 * hgt_eff) begin
            span = 16 * hgt_eff;
            case (face)
                FACE_NX, FACE_PX: begin
                    x = idx / span;
                    y = idx % 16;
                    z = (idx % span) / 16;
                end
                FACE_NY, FACE_PY: begin
                    x = idx % 16;
                    y = idx / span;
                    z = (idx % span) / 16;
                end
                default: begin
                    x = idx % 16;
                    y = (idx / 16) % 16;
                    z = idx / 256;
                end
            endcase
            nx     = x;
            ny     = y;
            nz     = z;
            has_nb = 1'b1;
            case (face)
                FACE_NX: if (x == 0)  has_nb = 1'b0; else nx = x - 1;
                FACE_PX: if (x == 15) has_nb = 1'b0; else nx = x + 1;
                FACE_NY: if (y == 0)  has_nb = 1'b0; else ny = y - 1;
                FACE_PY: if (y == 15) has_nb = 1'b0; else ny = y + 1;
                FACE_NZ: if (z == 0)  has_nb = 1'b0; else nz = z - 1;
                default: if (z + 1 >= hgt_eff) has_nb = 1'b0; else nz = z + 1;
            endcase
            fill_cell(x, y, z);
            if (has_nb)
                fill_cell(nx, ny, nz);
        end
        send_word(make_word(CMD_QUERY, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                            6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)), face,
                            14'(idx)));
    endtask

    // drain the block, let it settle, then program a new height
    task automatic set_height(input logic [HGT_W-1:0] value);
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (24) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we  <= 1'b0;
        hgt_eff = (int'(value) > MAX_LAYERS) ? MAX_LAYERS : int'(value);
    endtask

    // mostly well-formed loads, puts and queries, some errors and noise
    task automatic random_item();
        int unsigned r;
        t_in         w;
        if (hgt_eff == 0) begin
            send_word(random_word(2'($urandom_range(0, 3))));
            return;
        end
        r = $urandom_range(0, 99);
        if (r < 30) begin
            load_cell(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                      6'($urandom_range(0, hgt_eff - 1)), random_code());
        end else if (r < 50) begin
            put_cell(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                     6'($urandom_range(0, hgt_eff - 1)), random_code());
        end else if (r < 88) begin
            query_texel(3'($urandom_range(0, 5)), $urandom_range(0, 256 * hgt_eff - 1));
        end else begin
            w = random_word(CMD_NONE);
            case ($urandom_range(0, 3))
                1: if (hgt_eff < MAX_LAYERS) begin
                    w.cmd    = $urandom_range(0, 1) ? CMD_PUT : CMD_LOAD;
                    w.cell_z = 6'($urandom_range(hgt_eff, 63));
                end
                2: if (hgt_eff < MAX_LAYERS) begin
                    w.cmd         = CMD_QUERY;
                    w.texel_index = 14'($urandom_range(256 * hgt_eff, MAX_INDEX));
                end
                3: begin
                    w.cmd  = CMD_QUERY;
                    w.face = 3'($urandom_range(FACE_ODD_LO, FACE_ODD_HI));
                end
                default: ;
            endcase
            send_word(w);
        end
    endtask

    task automatic random_burst(input int count);
        for (int k = 0; k < count; k++) begin
            if (k % 40 == 0)
                tx_quiet = ($urandom_range(0, 3) == 0);
            random_item();
        end
    endtask

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // one layer: writes, put accept and reject, every face, edges and errors
        set_height(7'd1);
        load_cell(4'd0, 4'd0, 6'd0, 8'd1);
        load_cell(4'd15, 4'd15, 6'd0, 8'hFF);
        load_cell(4'd1, 4'd0, 6'd0, 8'd0);
        load_cell(4'd0, 4'd1, 6'd0, 8'd6);
        put_cell(4'd1, 4'd0, 6'd0, 8'd3);
        put_cell(4'd0, 4'd0, 6'd0, 8'd2);
        put_cell(4'd15, 4'd15, 6'd0, 8'd0);
        load_cell(4'd15, 4'd15, 6'd0, 8'd7);
        load_cell(4'd3, 4'd4, 6'd63, 8'd2);
        put_cell(4'd3, 4'd4, 6'd1, 8'd5);
        query_texel(FACE_NX, 0);
        query_texel(FACE_PX, 0);
        query_texel(FACE_NY, 0);
        query_texel(FACE_PY, 0);
        query_texel(FACE_NZ, 0);
        query_texel(FACE_PZ, 0);
        query_texel(FACE_PZ, 255);
        query_texel(FACE_PX, 255);
        query_texel(FACE_ODD_LO, 0);
        query_texel(FACE_ODD_HI, MAX_INDEX);
        query_texel(FACE_NZ, 256);
        send_word(make_word(CMD_NONE, 4'd15, 4'd15, 6'd63, 8'hFF, FACE_ODD_HI,
                            14'(MAX_INDEX)));
        random_burst(80);

        // zero height: every load, put and query reports an index error
        set_height(7'd0);
        load_cell(4'd0, 4'd0, 6'd0, 8'd4);
        put_cell(4'd0, 4'd0, 6'd0, 8'd0);
        query_texel(FACE_NZ, 0);
        send_word(make_word(CMD_NONE, 4'd0, 4'd0, 6'd0, 8'd0, FACE_NX, 14'd0));
        random_burst(12);

        // height past the store saturates; top corner of the chunk
        set_height(7'd127);
        load_cell(4'd15, 4'd15, 6'd63, 8'd5);
        query_texel(FACE_PZ, MAX_INDEX);
        query_texel(FACE_PX, MAX_INDEX);
        query_texel(FACE_NZ, MAX_INDEX);
        put_cell(4'd0, 4'd0, 6'd63, 8'd0);
        random_burst(45);

        // fill the block while results are held back
        set_height(7'd2);
        hold_req = 1'b1;
        random_burst(110);

        set_height(7'd64);
        random_burst(30);

        set_height(7'd3);
        random_burst(70);

        // closing stretch at full rate on both sides
        set_height(7'd1);
        allow_idle = 1'b0;
        random_burst(70);

        push <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (30) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
